/* hw/rtl/q24a_pkg.sv */
// Shared types, constants and helpers for the Q24.8 fixed-point ALU.
// Used by every module under hw/rtl; depends on nothing.
package q24a_pkg;

    localparam int DataW = 32;
    localparam int FracW = 8;
    localparam int NumW  = DataW + FracW;
    localparam int AccW  = DataW + NumW;
    localparam int ProdW = 2 * DataW;
    localparam int QW    = ProdW - FracW + 1;

    typedef enum logic [3:0] {
        OP_ADD      = 4'd0,
        OP_SUB      = 4'd1,
        OP_MUL      = 4'd2,
        OP_DIV      = 4'd3,
        OP_CMP      = 4'd4,
        OP_MIN      = 4'd5,
        OP_MAX      = 4'd6,
        OP_INC      = 4'd7,
        OP_DEC      = 4'd8,
        OP_TO_INT   = 4'd9,
        OP_FROM_INT = 4'd10
    } t_op;

    typedef enum logic [1:0] {
        K_PASS,
        K_MUL,
        K_DIV
    } t_kind;

    typedef struct packed {
        t_kind              kind;
        logic               neg;
        logic [DataW-1:0]   res;
        logic               lt;
        logic               eq;
        logic               gt;
        logic               ovf;
        logic               dz;
        logic [AccW-1:0]    acc;
        logic [DataW-1:0]   den;
    } t_word;

    function automatic logic [DataW:0] sat_wide(input logic [DataW:0] v);
        logic [DataW:0] r;
        if (v[DataW] != v[DataW-1]) begin
            r = {1'b1, v[DataW], {(DataW-1){~v[DataW]}}};
        end else begin
            r = {1'b0, v[DataW-1:0]};
        end
        return r;
    endfunction

endpackage

/* hw/rtl/q24a_prep.sv */
// Entry stage: decodes the opcode, does the simple operations and the multiply.
// Depends on q24a_pkg.
module q24a_prep (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [3:0]                  i_operation,
    input  logic [q24a_pkg::DataW-1:0]  i_a,
    input  logic [q24a_pkg::DataW-1:0]  i_b,
    output logic                        o_valid,
    output q24a_pkg::t_word             o_word,
    input  logic                        i_ready
);
    localparam int W = q24a_pkg::DataW;

    logic                       r_valid;
    q24a_pkg::t_word            r_word;
    q24a_pkg::t_word            n_word;
    logic [W-1:0]               mag_a;
    logic [W-1:0]               mag_b;
    logic [q24a_pkg::ProdW-1:0] prod;
    logic [W:0]                 sum_s;
    logic [W:0]                 dif_s;
    logic [W:0]                 inc_s;
    logic [W:0]                 dec_s;
    logic                       lt;
    logic                       gt;

    assign mag_a = i_a[W-1] ? W'(-i_a) : i_a;
    assign mag_b = i_b[W-1] ? W'(-i_b) : i_b;
    assign prod  = mag_a * mag_b;
    assign lt    = $signed(i_a) < $signed(i_b);
    assign gt    = $signed(i_a) > $signed(i_b);
    assign sum_s = q24a_pkg::sat_wide({i_a[W-1], i_a} + {i_b[W-1], i_b});
    assign dif_s = q24a_pkg::sat_wide({i_a[W-1], i_a} - {i_b[W-1], i_b});
    assign inc_s = q24a_pkg::sat_wide({i_a[W-1], i_a} + (W+1)'(1));
    assign dec_s = q24a_pkg::sat_wide({i_a[W-1], i_a} - (W+1)'(1));

    always_comb begin
        n_word      = '0;
        n_word.kind = q24a_pkg::K_PASS;
        unique case (q24a_pkg::t_op'(i_operation))
            q24a_pkg::OP_ADD: begin
                n_word.res = sum_s[W-1:0];
                n_word.ovf = sum_s[W];
            end
            q24a_pkg::OP_SUB: begin
                n_word.res = dif_s[W-1:0];
                n_word.ovf = dif_s[W];
            end
            q24a_pkg::OP_MUL: begin
                n_word.kind = q24a_pkg::K_MUL;
                n_word.neg  = i_a[W-1] ^ i_b[W-1];
                n_word.acc  = q24a_pkg::AccW'(prod);
            end
            q24a_pkg::OP_DIV: begin
                if (i_b == '0) begin
                    n_word.dz = 1'b1;
                end else begin
                    n_word.kind = q24a_pkg::K_DIV;
                    n_word.neg  = i_a[W-1] ^ i_b[W-1];
                    n_word.acc  = q24a_pkg::AccW'({mag_a, q24a_pkg::FracW'(0)});
                    n_word.den  = mag_b;
                end
            end
            q24a_pkg::OP_CMP: begin
                n_word.lt = lt;
                n_word.eq = (i_a == i_b);
                n_word.gt = gt;
            end
            q24a_pkg::OP_MIN: n_word.res = lt ? i_a : i_b;
            q24a_pkg::OP_MAX: n_word.res = gt ? i_a : i_b;
            q24a_pkg::OP_INC: begin
                n_word.res = inc_s[W-1:0];
                n_word.ovf = inc_s[W];
            end
            q24a_pkg::OP_DEC: begin
                n_word.res = dec_s[W-1:0];
                n_word.ovf = dec_s[W];
            end
            q24a_pkg::OP_TO_INT: n_word.res = W'($signed(i_a) >>> q24a_pkg::FracW);
            q24a_pkg::OP_FROM_INT: begin
                n_word.kind = q24a_pkg::K_MUL;
                n_word.neg  = i_b[W-1];
                n_word.acc  = q24a_pkg::AccW'(mag_b) << (2 * q24a_pkg::FracW);
            end
            default: n_word.kind = q24a_pkg::K_PASS;
        endcase
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_word <= n_word;
        end
    end

    assign o_valid = r_valid;
    assign o_word  = r_word;
endmodule

/* hw/rtl/q24a_div_cell.sv */
// One cell of the divider chain: a restoring step that yields one quotient bit.
// Other words pass through unchanged. Depends on q24a_pkg.
module q24a_div_cell (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  q24a_pkg::t_word i_word,
    output logic            o_valid,
    output q24a_pkg::t_word o_word,
    input  logic            i_ready
);
    localparam int W = q24a_pkg::DataW;
    localparam int N = q24a_pkg::NumW;

    logic               r_valid;
    q24a_pkg::t_word    r_word;
    q24a_pkg::t_word    n_word;
    logic [W-1:0]       rem;
    logic [N-1:0]       num;
    logic [W-1:0]       shifted;
    logic [W:0]         diff;
    logic               qbit;

    assign rem     = i_word.acc[q24a_pkg::AccW-1:N];
    assign num     = i_word.acc[N-1:0];
    assign shifted = {rem[W-2:0], num[N-1]};
    assign diff    = {1'b0, shifted} - {1'b0, i_word.den};
    assign qbit    = !diff[W];

    always_comb begin
        n_word = i_word;
        if (i_word.kind == q24a_pkg::K_DIV) begin
            n_word.acc = {(qbit ? diff[W-1:0] : shifted), num[N-2:0], qbit};
        end
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_word <= n_word;
        end
    end

    assign o_valid = r_valid;
    assign o_word  = r_word;
endmodule

/* hw/rtl/q24a_fin.sv */
// Output stage: rounds multiply and divide results, saturates, holds the result word.
// Depends on q24a_pkg.
module q24a_fin (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  q24a_pkg::t_word             i_word,
    output logic                        o_valid,
    output logic [q24a_pkg::DataW-1:0]  o_result,
    output logic                        o_less,
    output logic                        o_equal,
    output logic                        o_greater,
    output logic                        o_overflow,
    output logic                        o_divide_by_zero,
    input  logic                        i_ready
);
    localparam int W  = q24a_pkg::DataW;
    localparam int N  = q24a_pkg::NumW;
    localparam int QW = q24a_pkg::QW;
    localparam int PW = q24a_pkg::ProdW;

    logic               r_valid;
    q24a_pkg::t_word    r_word;
    q24a_pkg::t_word    n_word;
    logic [PW-1:0]      prod_r;
    logic               rnd;
    logic [QW-1:0]      qm;
    logic [QW-1:0]      lim_pos;
    logic [QW-1:0]      lim_neg;

    assign lim_pos = QW'({1'b0, {(W-1){1'b1}}});
    assign lim_neg = QW'(1) << (W - 1);
    assign prod_r  = i_word.acc[PW-1:0] + (PW'(1) << (q24a_pkg::FracW - 1));
    assign rnd     = {i_word.acc[q24a_pkg::AccW-1:N], 1'b0} >= {1'b0, i_word.den};

    always_comb begin
        n_word = i_word;
        qm     = '0;
        unique case (i_word.kind)
            q24a_pkg::K_MUL: qm = QW'(prod_r >> q24a_pkg::FracW);
            q24a_pkg::K_DIV: qm = QW'(i_word.acc[N-1:0]) + QW'(rnd);
            default:         qm = '0;
        endcase
        if (i_word.kind != q24a_pkg::K_PASS) begin
            if (i_word.neg) begin
                n_word.ovf = qm > lim_neg;
                n_word.res = (qm > lim_neg) ? {1'b1, {(W-1){1'b0}}} : W'(-qm[W-1:0]);
            end else begin
                n_word.ovf = qm > lim_pos;
                n_word.res = (qm > lim_pos) ? {1'b0, {(W-1){1'b1}}} : qm[W-1:0];
            end
        end
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_word <= n_word;
        end
    end

    assign o_valid          = r_valid;
    assign o_result         = r_word.res;
    assign o_less           = r_word.lt;
    assign o_equal          = r_word.eq;
    assign o_greater        = r_word.gt;
    assign o_overflow       = r_word.ovf;
    assign o_divide_by_zero = r_word.dz;
endmodule

/* hw/rtl/fixed_point_q24_8_alu.sv */
// Top level of the signed Q24.8 fixed-point ALU: entry stage, divider cell chain, output stage.
// Depends on q24a_pkg, q24a_prep, q24a_div_cell and q24a_fin.
//
// Usage:
//   Input channel: i_valid with i_operation, i_operand_a, i_operand_b; the block
//   raises o_stall when it cannot take a word. A word is taken at an edge with
//   i_valid high and o_stall low.
//   Output channel: o_valid with o_result and the five flags; the receiver
//   raises i_stall to hold the word, which then stays unchanged.
//   Every opcode takes the same path: one entry stage, 40 divider cells, one output stage;
//   one word per cycle is sustained while the receiver keeps i_stall low.
//   The length is set by the divider chain, one quotient bit per cell.
//   Each stage advances when its successor is empty or advancing, so bubbles
//   close up and new words are taken while a finished result waits.
//   Under a long stall the pipeline fills, holds 42 words, then raises o_stall.
//   Reset (synchronous, active low) empties every stage; no result is pending.
module fixed_point_q24_8_alu (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [3:0]  i_operation,
    input  logic [31:0] i_operand_a,
    input  logic [31:0] i_operand_b,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_result,
    output logic        o_less,
    output logic        o_equal,
    output logic        o_greater,
    output logic        o_overflow,
    output logic        o_divide_by_zero
);
    localparam int N = q24a_pkg::NumW;

    q24a_pkg::t_word    w_word [0:N];
    logic               w_valid [0:N];
    logic               w_ready [0:N];
    logic               prep_ready;

    q24a_prep u_prep (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (prep_ready),
        .i_operation (i_operation),
        .i_a         (i_operand_a),
        .i_b         (i_operand_b),
        .o_valid     (w_valid[0]),
        .o_word      (w_word[0]),
        .i_ready     (w_ready[0])
    );

    for (genvar k = 0; k < N; k++) begin : g_cell
        q24a_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_valid[k]),
            .o_ready (w_ready[k]),
            .i_word  (w_word[k]),
            .o_valid (w_valid[k+1]),
            .o_word  (w_word[k+1]),
            .i_ready (w_ready[k+1])
        );
    end

    q24a_fin u_fin (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (w_valid[N]),
        .o_ready          (w_ready[N]),
        .i_word           (w_word[N]),
        .o_valid          (o_valid),
        .o_result         (o_result),
        .o_less           (o_less),
        .o_equal          (o_equal),
        .o_greater        (o_greater),
        .o_overflow       (o_overflow),
        .o_divide_by_zero (o_divide_by_zero),
        .i_ready          (!i_stall)
    );

    assign o_stall = !prep_ready;

    a_cmp_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $onehot0({o_less, o_equal, o_greater}))
        else $error("more than one compare flag set");

    a_dz_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_divide_by_zero |-> o_result == '0 && !o_overflow)
        else $error("divide by zero with nonzero result or overflow");

    a_cmp_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_less || o_equal || o_greater) |-> o_result == '0 && !o_overflow)
        else $error("compare word with nonzero result");

    a_ovf_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_overflow |-> o_result == 32'h7fff_ffff || o_result == 32'h8000_0000)
        else $error("overflow without saturated result");
endmodule

/* tb/sv/tb_fixed_point_q24_8_alu.sv */
// Self-checking testbench for the Q24.8 fixed-point ALU: directed and random words,
// random gaps and output stalls, each result checked against an exact integer predictor.
// Depends on q24a_pkg and fixed_point_q24_8_alu.
module tb_fixed_point_q24_8_alu;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 400000;
    localparam int RANDOM_WORDS = 1880;
    localparam logic [31:0] QMAX = 32'h7fff_ffff;
    localparam logic [31:0] QMIN = 32'h8000_0000;

    typedef struct {
        logic [3:0]  op;
        logic [31:0] a;
        logic [31:0] b;
        bit          drain;
    } t_alu_word;

    typedef struct packed {
        logic [31:0] result;
        logic        lt;
        logic        eq;
        logic        gt;
        logic        ovf;
        logic        dz;
    } t_alu_res;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [3:0]  i_operation;
    logic [31:0] i_operand_a;
    logic [31:0] i_operand_b;
    logic        o_valid;
    logic        i_stall;
    logic [31:0] o_result;
    logic        o_less;
    logic        o_equal;
    logic        o_greater;
    logic        o_overflow;
    logic        o_divide_by_zero;

    t_alu_word pending_words[$];
    t_alu_res  expected_results[$];
    bit        in_taken;
    bit        out_taken;
    bit        send_quiet;
    bit        recv_quiet;
    int        send_gap;
    int        stall_left;
    int        mismatches;
    int        checked;
    int        cycles;
    int        op_count[16];

    fixed_point_q24_8_alu DUT (.*);

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic t_alu_res alu_predict(logic [3:0] op, logic [31:0] a_raw,
                                             logic [31:0] b_raw);
        t_alu_res    r;
        longint      sa;
        longint      sb;
        longint      w;
        logic [63:0] ma;
        logic [63:0] mb;
        logic [63:0] q;
        bit          neg;
        bit          clamp;
        sa = longint'($signed(a_raw));
        sb = longint'($signed(b_raw));
        ma = (sa < 0) ? 64'(-sa) : 64'(sa);
        mb = (sb < 0) ? 64'(-sb) : 64'(sb);
        neg = (sa < 0) != (sb < 0);
        r = '0;
        w = 0;
        clamp = 1'b1;
        case (op)
            q24a_pkg::OP_ADD: w = sa + sb;
            q24a_pkg::OP_SUB: w = sa - sb;
            q24a_pkg::OP_MUL: begin
                q = (ma * mb + (64'd1 << (q24a_pkg::FracW - 1))) >> q24a_pkg::FracW;
                w = neg ? -longint'(q) : longint'(q);
            end
            q24a_pkg::OP_DIV: begin
                if (sb == 0) begin
                    r.dz = 1'b1;
                    clamp = 1'b0;
                end else begin
                    q = (2 * (ma << q24a_pkg::FracW) + mb) / (2 * mb);
                    w = neg ? -longint'(q) : longint'(q);
                end
            end
            q24a_pkg::OP_CMP: begin
                r.lt = sa < sb;
                r.eq = sa == sb;
                r.gt = sa > sb;
            end
            q24a_pkg::OP_MIN: w = (sa < sb) ? sa : sb;
            q24a_pkg::OP_MAX: w = (sa > sb) ? sa : sb;
            q24a_pkg::OP_INC: w = sa + 1;
            q24a_pkg::OP_DEC: w = sa - 1;
            q24a_pkg::OP_TO_INT: w = sa >>> q24a_pkg::FracW;
            q24a_pkg::OP_FROM_INT: begin
                q = mb << q24a_pkg::FracW;
                w = (sb < 0) ? -longint'(q) : longint'(q);
            end
            default: clamp = 1'b0;
        endcase
        if (clamp && w > 64'sd2147483647) begin
            r.ovf = 1'b1;
            w = 64'sd2147483647;
        end else if (clamp && w < -64'sd2147483648) begin
            r.ovf = 1'b1;
            w = -64'sd2147483648;
        end
        r.result = w[31:0];
        return r;
    endfunction

    function automatic logic [31:0] rand_operand();
        case ($urandom_range(0, 9))
            0: return QMAX - $urandom_range(0, 3);
            1: return QMIN + $urandom_range(0, 3);
            2: return 32'($signed($urandom_range(0, 4096)) - 2048);
            3: return 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
            4: return 32'(0);
            default: return $urandom;
        endcase
    endfunction

    task automatic queue_word(logic [3:0] op, logic [31:0] a, logic [31:0] b, bit drain = 0);
        t_alu_word w;
        w.op = op;
        w.a = a;
        w.b = b;
        w.drain = drain;
        pending_words.push_back(w);
    endtask

    function automatic int draw_wait(bit quiet);
        return quiet ? 0 : $urandom_range(0, 13);
    endfunction

    // sample handshakes, predict accepted words, check results
    always @(posedge i_clk) begin
        t_alu_res got;
        t_alu_res exp_r;
        cycles <= cycles + 1;
        if (!i_rst_n) begin
            in_taken <= 1'b0;
            out_taken <= 1'b0;
        end else begin
            in_taken <= i_valid && !o_stall;
            out_taken <= o_valid && !i_stall;
            if (i_valid && !o_stall) begin
                expected_results.push_back(alu_predict(i_operation, i_operand_a, i_operand_b));
                op_count[i_operation] <= op_count[i_operation] + 1;
            end
            if (o_valid && !i_stall) begin
                got = {o_result, o_less, o_equal, o_greater, o_overflow, o_divide_by_zero};
                checked <= checked + 1;
                if (expected_results.size() == 0) begin
                    mismatches <= mismatches + 1;
                    if (mismatches < 10)
                        $display("unexpected result word %h", got);
                end else begin
                    exp_r = expected_results.pop_front();
                    if (got !== exp_r) begin
                        mismatches <= mismatches + 1;
                        if (mismatches < 10)
                            $display("mismatch: expected res=%h lt%b eq%b gt%b ovf%b dz%b, got res=%h lt%b eq%b gt%b ovf%b dz%b",
                                exp_r.result, exp_r.lt, exp_r.eq, exp_r.gt, exp_r.ovf, exp_r.dz,
                                got.result, got.lt, got.eq, got.gt, got.ovf, got.dz);
                    end
                end
            end
        end
    end

    // drive input words
    always @(negedge i_clk) begin
        t_alu_word w;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (i_valid && !in_taken) begin
            // hold
        end else if (send_gap > 0) begin
            i_valid <= 1'b0;
            send_gap <= send_gap - 1;
        end else if (pending_words.size() > 0 &&
                     !(pending_words[0].drain && (expected_results.size() > 0 || i_valid))) begin
            w = pending_words.pop_front();
            i_valid <= 1'b1;
            i_operation <= w.op;
            i_operand_a <= w.a;
            i_operand_b <= w.b;
            if ($urandom_range(0, 39) == 0)
                send_quiet <= !send_quiet;
            send_gap <= draw_wait(send_quiet);
        end else begin
            i_valid <= 1'b0;
        end
    end

    // drive output stall
    always @(negedge i_clk) begin
        int stall_draw;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else if (out_taken) begin
            if ($urandom_range(0, 39) == 0)
                recv_quiet <= !recv_quiet;
            stall_draw = draw_wait(recv_quiet);
            if (stall_draw > 0) begin
                i_stall <= 1'b1;
                stall_left <= stall_draw - 1;
            end else begin
                i_stall <= 1'b0;
                stall_left <= 0;
            end
        end else if (stall_left > 0) begin
            i_stall <= 1'b1;
            stall_left <= stall_left - 1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        if (cycles > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin
        logic [3:0] op;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_stall = 1'b0;
        i_operation = q24a_pkg::OP_ADD;
        i_operand_a = '0;
        i_operand_b = '0;
        in_taken = 0;
        out_taken = 0;
        send_quiet = 0;
        recv_quiet = 0;
        send_gap = 0;
        stall_left = 0;
        mismatches = 0;
        checked = 0;
        cycles = 0;
        foreach (op_count[i]) op_count[i] = 0;

        queue_word(q24a_pkg::OP_ADD, QMAX, QMAX);
        queue_word(q24a_pkg::OP_ADD, QMIN, QMIN);
        queue_word(q24a_pkg::OP_SUB, QMIN, 32'd1);
        queue_word(q24a_pkg::OP_SUB, QMAX, QMIN);
        queue_word(q24a_pkg::OP_MUL, QMIN, QMIN);
        queue_word(q24a_pkg::OP_MUL, 32'h0000_0180, 32'hffff_ff80);
        queue_word(q24a_pkg::OP_MUL, 32'hffff_ffff, 32'h0000_0080);
        queue_word(q24a_pkg::OP_DIV, 32'h0000_0500, 32'd0);
        queue_word(q24a_pkg::OP_DIV, QMIN, 32'hffff_ff00);
        queue_word(q24a_pkg::OP_DIV, 32'hffff_ff00, 32'h0000_0300);
        queue_word(q24a_pkg::OP_DIV, QMAX, 32'd1);
        queue_word(q24a_pkg::OP_CMP, 32'hffff_ff00, 32'h0000_0100);
        queue_word(q24a_pkg::OP_CMP, QMIN, QMIN);
        queue_word(q24a_pkg::OP_CMP, QMAX, QMIN);
        queue_word(q24a_pkg::OP_MIN, QMIN, QMAX);
        queue_word(q24a_pkg::OP_MAX, QMIN, QMAX);
        queue_word(q24a_pkg::OP_MAX, 32'd7, 32'd7);
        queue_word(q24a_pkg::OP_INC, QMAX, 32'd0);
        queue_word(q24a_pkg::OP_DEC, QMIN, 32'd0);
        queue_word(q24a_pkg::OP_TO_INT, 32'hffff_fe80, 32'd0);
        queue_word(q24a_pkg::OP_TO_INT, QMAX, QMIN);
        queue_word(q24a_pkg::OP_FROM_INT, 32'd0, 32'h0080_0000);
        queue_word(q24a_pkg::OP_FROM_INT, 32'd0, 32'hff80_0000);
        queue_word(4'hb, QMAX, QMIN);
        queue_word(4'hf, QMIN, QMAX);

        for (int n = 0; n < RANDOM_WORDS; n++) begin
            op = ($urandom_range(0, 15) == 0) ? 4'($urandom_range(11, 15))
                                                : 4'($urandom_range(0, 10));
            queue_word(op, rand_operand(), rand_operand(), n == RANDOM_WORDS / 2);
        end

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_words.size() > 0 || i_valid || expected_results.size() > 0)
            @(posedge i_clk);
        repeat (60) @(posedge i_clk);

        if (expected_results.size() > 0)
            mismatches = mismatches + expected_results.size();
        $display("checked %0d results; add %0d sub %0d mul %0d div %0d cmp %0d min %0d max %0d",
                 checked, op_count[q24a_pkg::OP_ADD], op_count[q24a_pkg::OP_SUB],
                 op_count[q24a_pkg::OP_MUL], op_count[q24a_pkg::OP_DIV],
                 op_count[q24a_pkg::OP_CMP], op_count[q24a_pkg::OP_MIN],
                 op_count[q24a_pkg::OP_MAX]);
        $display("inc %0d dec %0d to_int %0d from_int %0d; %0d mismatches",
                 op_count[q24a_pkg::OP_INC], op_count[q24a_pkg::OP_DEC],
                 op_count[q24a_pkg::OP_TO_INT], op_count[q24a_pkg::OP_FROM_INT], mismatches);
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule
